// ===== rtl/core/eldf_pkg.sv =====
// shared types and constants for the escaped link demux with keyboard and file fifos
// no dependencies
`default_nettype none

package eldf_pkg;

    localparam int DATA_W = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        FUNC_RECV     = 2'd0,
        FUNC_POP_KEY  = 2'd1,
        FUNC_POP_FILE = 2'd2,
        FUNC_SEND     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_ACK = 2'd0,
        KIND_POP = 2'd1,
        KIND_TX  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SRC_DIRECT = 2'd0,
        SRC_KEY    = 2'd1,
        SRC_FILE   = 2'd2
    } t_src;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPED_ESCAPE_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYBOARD_CODE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NADA_CODE           = 3'd4;

    localparam logic [DATA_W-1:0] RST_ESCAPE_CODE         = 8'd27;
    localparam logic [DATA_W-1:0] RST_ESCAPED_ESCAPE_CODE = 8'd1;
    localparam logic [DATA_W-1:0] RST_KEYBOARD_CODE       = 8'd8;
    localparam logic [DATA_W-1:0] RST_NADA_CODE           = 8'd0;

    // one item between accept stage and output register
    typedef struct packed {
        t_kind             kind;
        t_src              src;
        logic              dbl;
        logic [DATA_W-1:0] data0;
        logic [DATA_W-1:0] data;
        logic              key_av;
        logic              file_av;
        logic              ovf;
        logic              last;
    } t_s1;

endpackage

`default_nettype wire

// ===== rtl/core/eldf_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module eldf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/escaped_link_demux_fifos.sv =====
// escaped link demux: escape decoding into a keyboard fifo and a file fifo, pops and sends
// an accepted transaction is registered in the s1 stage, then in the output register
// throughput: one item per cycle unless the output stalls; a send of the escape byte gives two
// results through the single output register; fifo pop data comes from the ram registered read port
// reset: synchronous active low, clears indices, escape flags and valid bits, loads config registers
// with their reset values; fifo memories are not cleared
`default_nettype none

module escaped_link_demux_fifos #(
    parameter int KEY_DEPTH  = 64,
    parameter int FILE_DEPTH = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [eldf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [eldf_pkg::DATA_W-1:0]        i_cfg_data,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [7:0]                         i_s_tdata,   // data
    input  wire logic [1:0]                         i_s_tuser,   // func
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic      [15:0]                        o_m_tdata,   // data_out, data_valid,
                                                                 // key_available,
                                                                 // file_available, overflow
    output logic      [1:0]                         o_m_tuser,   // kind
    output logic                                    o_m_tlast
);

    localparam int KAW = $clog2(KEY_DEPTH);
    localparam int KIW = KAW + 1;
    localparam int FAW = $clog2(FILE_DEPTH);
    localparam int FIW = FAW + 1;
    localparam logic [KIW-1:0] KEY_D    = KIW'(KEY_DEPTH);
    localparam logic [KIW-1:0] KEY_LAST = KIW'(2 * KEY_DEPTH - 1);
    localparam logic [FIW-1:0] FILE_D    = FIW'(FILE_DEPTH);
    localparam logic [FIW-1:0] FILE_LAST = FIW'(2 * FILE_DEPTH - 1);

    // config
    logic       r_link_en;
    logic [7:0] r_esc;
    logic [7:0] r_eesc;
    logic [7:0] r_kbd;
    logic [7:0] r_nada;

    // state
    logic [KIW-1:0] r_key_wr, r_key_rd, n_key_wr, n_key_rd;
    logic [FIW-1:0] r_file_wr, r_file_rd, n_file_wr, n_file_rd;
    logic           r_after_esc, n_after_esc;
    logic           r_key_next, n_key_next;

    logic [KAW-1:0] key_waddr, key_raddr;
    logic [FAW-1:0] file_waddr, file_raddr;
    logic           key_empty, key_full, file_empty, file_full;

    logic              push_key, push_file, pop_key, pop_file;
    logic              key_we, file_we, key_re, file_re;
    logic [7:0]        file_wdata;
    logic [7:0]        rcv;
    logic              ae;
    eldf_pkg::t_func   func;
    eldf_pkg::t_s1     entry;

    logic [7:0] key_rdata, file_rdata;

    eldf_pkg::t_s1 r_s1;
    logic          r_s1_valid;
    logic          r_s1_second;

    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_data;
    logic       r_out_dv;
    logic       r_out_key_av;
    logic       r_out_file_av;
    logic       r_out_ovf;
    logic       r_out_last;

    logic       out_free, s1_take, s1_beat0, s1_done, accept;
    logic [7:0] s1_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_en <= 1'b0;
            r_esc     <= eldf_pkg::RST_ESCAPE_CODE;
            r_eesc    <= eldf_pkg::RST_ESCAPED_ESCAPE_CODE;
            r_kbd     <= eldf_pkg::RST_KEYBOARD_CODE;
            r_nada    <= eldf_pkg::RST_NADA_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                eldf_pkg::CFG_LINK_ENABLED:        r_link_en <= i_cfg_data[0];
                eldf_pkg::CFG_ESCAPE_CODE:         r_esc     <= i_cfg_data;
                eldf_pkg::CFG_ESCAPED_ESCAPE_CODE: r_eesc    <= i_cfg_data;
                eldf_pkg::CFG_KEYBOARD_CODE:       r_kbd     <= i_cfg_data;
                eldf_pkg::CFG_NADA_CODE:           r_nada    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // fifo addresses and levels
    always_comb begin
        key_waddr  = (r_key_wr < KEY_D) ? r_key_wr[KAW-1:0] : KAW'(r_key_wr - KEY_D);
        key_raddr  = (r_key_rd < KEY_D) ? r_key_rd[KAW-1:0] : KAW'(r_key_rd - KEY_D);
        file_waddr = (r_file_wr < FILE_D) ? r_file_wr[FAW-1:0] : FAW'(r_file_wr - FILE_D);
        file_raddr = (r_file_rd < FILE_D) ? r_file_rd[FAW-1:0] : FAW'(r_file_rd - FILE_D);
        key_empty  = (r_key_wr == r_key_rd);
        file_empty = (r_file_wr == r_file_rd);
        key_full   = (key_waddr == key_raddr) && !key_empty;
        file_full  = (file_waddr == file_raddr) && !file_empty;
    end

    // output handshake
    always_comb begin
        out_free = !r_out_valid || i_m_tready;
        s1_take  = r_s1_valid && out_free;
        s1_beat0 = r_s1.dbl && !r_s1_second;
        s1_done  = s1_take && !s1_beat0;
        o_s_tready = !r_s1_valid || s1_done;
        accept   = i_s_tvalid && o_s_tready;
    end

    // accept stage: escape rules and fifo bookkeeping
    always_comb begin
        func        = eldf_pkg::t_func'(i_s_tuser);
        rcv         = i_s_tdata;
        ae          = r_after_esc;
        n_after_esc = r_after_esc;
        n_key_next  = r_key_next;
        push_key    = 1'b0;
        push_file   = 1'b0;
        pop_key     = 1'b0;
        pop_file    = 1'b0;
        file_wdata  = i_s_tdata;
        entry       = '0;
        entry.kind  = eldf_pkg::KIND_ACK;
        entry.src   = eldf_pkg::SRC_DIRECT;
        if (r_link_en) begin
            entry.last = 1'b1;
            case (func)
                eldf_pkg::FUNC_RECV: begin
                    if (r_key_next) begin
                        push_key   = 1'b1;
                        n_key_next = 1'b0;
                        ae         = 1'b1;
                        rcv        = r_nada;
                    end
                    if (ae) begin
                        n_after_esc = 1'b0;
                        if (rcv == r_eesc) begin
                            push_file  = 1'b1;
                            file_wdata = r_esc;
                        end else if (rcv == r_kbd) begin
                            n_key_next = 1'b1;
                        end
                    end else if (rcv == r_esc) begin
                        n_after_esc = 1'b1;
                    end else begin
                        push_file  = 1'b1;
                        file_wdata = rcv;
                    end
                    entry.ovf = (push_key && key_full) || (push_file && file_full);
                end
                eldf_pkg::FUNC_POP_KEY: begin
                    if (!key_empty) begin
                        pop_key    = 1'b1;
                        entry.kind = eldf_pkg::KIND_POP;
                        entry.src  = eldf_pkg::SRC_KEY;
                    end
                end
                eldf_pkg::FUNC_POP_FILE: begin
                    if (!file_empty) begin
                        pop_file   = 1'b1;
                        entry.kind = eldf_pkg::KIND_POP;
                        entry.src  = eldf_pkg::SRC_FILE;
                    end
                end
                eldf_pkg::FUNC_SEND: begin
                    entry.kind = eldf_pkg::KIND_TX;
                    if (i_s_tdata == r_esc) begin
                        entry.dbl   = 1'b1;
                        entry.data0 = i_s_tdata;
                        entry.data  = r_eesc;
                    end else begin
                        entry.data  = i_s_tdata;
                    end
                end
                default: ;
            endcase
        end

        key_we  = accept && push_key && !key_full;
        file_we = accept && push_file && !file_full;
        key_re  = accept && pop_key;
        file_re = accept && pop_file;

        n_key_wr  = (push_key && !key_full) ?
                    ((r_key_wr == KEY_LAST) ? '0 : r_key_wr + 1'b1) : r_key_wr;
        n_key_rd  = pop_key ? ((r_key_rd == KEY_LAST) ? '0 : r_key_rd + 1'b1) : r_key_rd;
        n_file_wr = (push_file && !file_full) ?
                    ((r_file_wr == FILE_LAST) ? '0 : r_file_wr + 1'b1) : r_file_wr;
        n_file_rd = pop_file ?
                    ((r_file_rd == FILE_LAST) ? '0 : r_file_rd + 1'b1) : r_file_rd;

        if (r_link_en) begin
            entry.key_av  = (n_key_wr != n_key_rd);
            entry.file_av = (n_file_wr != n_file_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_wr    <= '0;
            r_key_rd    <= '0;
            r_file_wr   <= '0;
            r_file_rd   <= '0;
            r_after_esc <= 1'b0;
            r_key_next  <= 1'b0;
        end else if (accept) begin
            r_key_wr    <= n_key_wr;
            r_key_rd    <= n_key_rd;
            r_file_wr   <= n_file_wr;
            r_file_rd   <= n_file_rd;
            r_after_esc <= n_after_esc;
            r_key_next  <= n_key_next;
        end
    end

    eldf_ram #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (i_s_tdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    eldf_ram #(
        .WIDTH (8),
        .DEPTH (FILE_DEPTH)
    ) u_file_ram (
        .i_clk   (i_clk),
        .i_we    (file_we),
        .i_waddr (file_waddr),
        .i_wdata (file_wdata),
        .i_re    (file_re),
        .i_raddr (file_raddr),
        .o_rdata (file_rdata)
    );

    // stage holding the item while the ram read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_second <= 1'b0;
        end else begin
            if (s1_take) begin
                r_s1_second <= s1_beat0;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1       <= entry;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (r_s1.src)
            eldf_pkg::SRC_KEY:  s1_data = key_rdata;
            eldf_pkg::SRC_FILE: s1_data = file_rdata;
            default:            s1_data = r_s1.data;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take) begin
            r_out_valid   <= 1'b1;
            r_out_kind    <= r_s1.kind;
            r_out_data    <= s1_beat0 ? r_s1.data0 : s1_data;
            r_out_dv      <= (r_s1.kind != eldf_pkg::KIND_ACK);
            r_out_key_av  <= r_s1.key_av;
            r_out_file_av <= r_s1.file_av;
            r_out_ovf     <= r_s1.ovf;
            r_out_last    <= s1_beat0 ? 1'b0 : r_s1.last;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {4'b0000, r_out_ovf, r_out_file_av, r_out_key_av, r_out_dv, r_out_data};

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_key_wr <= KEY_LAST) && (r_key_rd <= KEY_LAST) &&
        (r_file_wr <= FILE_LAST) && (r_file_rd <= FILE_LAST))
        else $error("fifo index out of range");

    a_pop_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_re |=> r_s1_valid && (r_s1.src == eldf_pkg::SRC_KEY))
        else $error("key pop not held in stage");

    a_second_dbl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_second) |-> r_s1.dbl)
        else $error("second beat without escape send");

    a_beat0_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last && (r_out_kind == eldf_pkg::KIND_TX))
        |-> (r_s1_valid && r_s1_second))
        else $error("escape send first beat without pending second beat");
`endif

endmodule

`default_nettype wire
